// ===== rtl/bmp_pixel_row_encoder_defines.svh =====
// Assertion macros shared by the pixel row encoder RTL.
`ifndef BMP_PIXEL_ROW_ENCODER_DEFINES_SVH
`define BMP_PIXEL_ROW_ENCODER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define BPRE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpre assertion failed");
// next-cycle implication
`define BPRE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpre assertion failed");
`else
`define BPRE_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPRE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/bpre_pkg.sv =====
// Shared types and constants of the pixel row encoder.
package bpre_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int MAX_WIDTH_DEF     = 4096;
   localparam int QUEUE_DEPTH       = 2;

   localparam int BYTE_W     = 8;
   localparam int MODE_W     = 2;
   localparam int ROW_W      = 13;
   localparam int PCOUNT_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // pixel modes
   localparam logic [MODE_W-1:0] MODE_PAL8   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RGB555 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BGR24  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_COUNT = 2'd2;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   localparam logic [BYTE_W-1:0] NO_MATCH = 8'd255;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ROW_W-1:0]    row_width;
      logic [PCOUNT_W-1:0] palette_count;
   } cfg_type;

   // one pixel's worth of output: data bytes then padding zeros
   typedef struct packed {
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [1:0]        nbytes;
      logic [1:0]        npad;
   } job_type;

endpackage

// ===== rtl/bpre_req_if.sv =====
// Input item channel of the pixel row encoder.
interface bpre_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] entry_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, kind, entry_index, red, green, blue, input ready);
   modport sink   (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

// ===== rtl/bpre_rsp_if.sv =====
// Output byte channel of the pixel row encoder.
interface bpre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_padding;
   logic       last_of_item;

   modport source (output valid, out_byte, is_padding, last_of_item, input ready);
   modport sink   (input valid, out_byte, is_padding, last_of_item, output ready);
endinterface

// ===== rtl/bpre_queue.sv =====
// Small job FIFO between the front and back ends.
`include "bmp_pixel_row_encoder_defines.svh"
module bpre_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  bpre_pkg::job_type job_i,
   output logic              full_o,
   input  logic              pop_i,
   output logic              empty_o,
   output bpre_pkg::job_type head_o
);
   localparam int DEPTH = bpre_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bpre_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= job_i;
      end
   end

   `BPRE_ASSERT_IMP(a_no_push_full, clock, reset, push_i, !full_o)
   `BPRE_ASSERT_IMP(a_no_pop_empty, clock, reset, pop_i, !empty_o)
endmodule

// ===== rtl/bpre_front.sv =====
// Front end: takes items, keeps the palette, searches it, builds byte jobs.
`include "bmp_pixel_row_encoder_defines.svh"
module bpre_front #(
   parameter int PALETTE_DEPTH = bpre_pkg::PALETTE_DEPTH_DEF,
   parameter int MAX_WIDTH     = bpre_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bpre_req_if.sink          req_ch,
   input  bpre_pkg::cfg_type cfg_i,
   output logic              push_o,
   output bpre_pkg::job_type job_o,
   input  logic              full_i
);
   localparam int PAL_IDX_W = $clog2(PALETTE_DEPTH);
   localparam int PCNT_W    = $clog2(PALETTE_DEPTH + 1);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int MAXW_BITS = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W     = (MAXW_BITS > bpre_pkg::ROW_W) ? MAXW_BITS : bpre_pkg::ROW_W;

   typedef enum logic [1:0] {F_IDLE, F_SEARCH, F_PUSH} state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PCNT_W-1:0] scan_ff, scan_in;
   logic              chk_ff, chk_in;
   logic [PAL_IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [23:0]       pix_ff, pix_in;
   bpre_pkg::job_type job_ff, job_in;

   logic [23:0]       palette_mem [PALETTE_DEPTH];
   logic [23:0]       rdata_ff;

   logic              accept, is_pixel, load_wr, rd_en;
   logic [PAL_IDX_W-1:0] rd_addr;
   logic [23:0]       rgb;
   logic [PCNT_W-1:0] n_eff;
   logic [CMP_W-1:0]  rw_ext, width_eff;
   logic              row_end;
   logic [1:0]        bpp;
   logic [3:0]        pad_prod;
   logic [4:0]        r5, g5, b5;
   bpre_pkg::job_type job_now;
   logic              hit, last_chk;

   assign req_ch.ready = (state_ff == F_IDLE) && !full_i;
   assign accept   = req_ch.valid && req_ch.ready;
   assign is_pixel = (req_ch.kind == bpre_pkg::KIND_PIXEL);
   assign rgb      = {req_ch.red, req_ch.green, req_ch.blue};
   assign load_wr  = accept && !is_pixel && (32'(req_ch.entry_index) < PALETTE_DEPTH);
   assign n_eff    = (32'(cfg_i.palette_count) > PALETTE_DEPTH) ?
                     PCNT_W'(PALETTE_DEPTH) : PCNT_W'(cfg_i.palette_count);
   assign rd_en    = (state_ff == F_SEARCH) && (scan_ff < n_eff);
   assign rd_addr  = scan_ff[PAL_IDX_W-1:0];
   assign hit      = chk_ff && (rdata_ff == pix_ff);
   assign last_chk = chk_ff && ((PCNT_W'(chk_idx_ff) + PCNT_W'(1)) == n_eff);

   // row geometry: zero width counts as one, oversize clamps
   always_comb begin
      rw_ext = CMP_W'(cfg_i.row_width);
      if (rw_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = rw_ext;
      end
      row_end = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;
   end

   // byte job for the item at the port
   always_comb begin
      r5 = req_ch.red[4:0];
      g5 = req_ch.green[4:0];
      b5 = req_ch.blue[4:0];
      job_now = '0;
      unique case (cfg_i.mode)
         bpre_pkg::MODE_PAL8: begin
            bpp            = 2'd1;
            job_now.b0     = bpre_pkg::NO_MATCH;
            job_now.nbytes = 2'd1;
         end
         bpre_pkg::MODE_RGB555: begin
            bpp            = 2'd2;
            job_now.b0     = {g5[2:0], b5};
            job_now.b1     = {1'b0, r5, g5[4:3]};
            job_now.nbytes = 2'd2;
         end
         default: begin
            bpp            = 2'd3;
            job_now.b0     = req_ch.blue;
            job_now.b1     = req_ch.green;
            job_now.b2     = req_ch.red;
            job_now.nbytes = 2'd3;
         end
      endcase
      pad_prod = bpp * width_eff[1:0];
      job_now.npad = row_end ? (2'd0 - pad_prod[1:0]) : 2'd0;
   end

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      scan_in    = scan_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      pix_in     = pix_ff;
      job_in     = job_ff;
      push_o     = 1'b0;
      job_o      = job_now;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && is_pixel) begin
               col_in = row_end ? '0 : col_ff + 1'b1;
               if (cfg_i.mode == bpre_pkg::MODE_PAL8 && n_eff != '0) begin
                  state_in = F_SEARCH;
                  scan_in  = '0;
                  pix_in   = rgb;
                  job_in   = job_now;
               end else begin
                  push_o = 1'b1;
               end
            end
         end
         F_SEARCH: begin
            // one palette entry per cycle, compare in the cycle after the read
            if (rd_en) begin
               scan_in    = scan_ff + 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = rd_addr;
            end
            if (hit) begin
               job_in.b0 = bpre_pkg::BYTE_W'(chk_idx_ff);
               state_in  = F_PUSH;
               chk_in    = 1'b0;
            end else if (last_chk) begin
               job_in.b0 = bpre_pkg::NO_MATCH;
               state_in  = F_PUSH;
               chk_in    = 1'b0;
            end
         end
         F_PUSH: begin
            job_o = job_ff;
            if (!full_i) begin
               push_o   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         chk_ff   <= chk_in;
      end
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      pix_ff     <= pix_in;
      job_ff     <= job_in;
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         palette_mem[req_ch.entry_index[PAL_IDX_W-1:0]] <= rgb;
      end
      if (rd_en) begin
         rdata_ff <= palette_mem[rd_addr];
      end
   end

   `BPRE_ASSERT_IMP(a_chk_in_range, clock, reset, chk_ff, (PCNT_W'(chk_idx_ff) < n_eff))
endmodule

// ===== rtl/bpre_back.sv =====
// Back end: turns queued jobs into one output byte per cycle while the output is ready.
`include "bmp_pixel_row_encoder_defines.svh"
module bpre_back (
   input  logic              clock,
   input  logic              reset,
   input  bpre_pkg::job_type head_i,
   input  logic              empty_i,
   output logic              pop_o,
   bpre_rsp_if.source        rsp_ch
);
   bpre_pkg::job_type cur_ff, cur_in;
   logic [2:0]        pos_ff, pos_in;
   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_pad_ff, out_pad_in;
   logic              out_last_ff, out_last_in;

   logic       adv, fin, in_pad;
   logic [2:0] total;
   logic [7:0] data_byte;

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.is_padding   = out_pad_ff;
   assign rsp_ch.last_of_item = out_last_ff;

   always_comb begin
      total  = 3'(cur_ff.nbytes) + 3'(cur_ff.npad);
      adv    = !out_valid_ff || rsp_ch.ready;
      fin    = busy_ff && (pos_ff == total - 3'd1);
      in_pad = (pos_ff >= 3'(cur_ff.nbytes));
      case (pos_ff)
         3'd0:    data_byte = cur_ff.b0;
         3'd1:    data_byte = cur_ff.b1;
         3'd2:    data_byte = cur_ff.b2;
         default: data_byte = '0;
      endcase
      pop_o = !empty_i && (!busy_ff || (adv && fin));

      cur_in       = cur_ff;
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_pad_in   = out_pad_ff;
      out_last_in  = out_last_ff;
      if (adv) begin
         out_valid_in = busy_ff;
         out_byte_in  = in_pad ? 8'd0 : data_byte;
         out_pad_in   = in_pad;
         out_last_in  = fin;
         if (busy_ff) begin
            if (fin) begin
               busy_in = 1'b0;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
      end
      // next job follows its predecessor's last byte without a gap
      if (pop_o) begin
         cur_in  = head_i;
         pos_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      out_byte_ff <= out_byte_in;
      out_pad_ff  <= out_pad_in;
      out_last_ff <= out_last_in;
   end

   `BPRE_ASSERT_IMP(a_pos_in_job, clock, reset, busy_ff, (pos_ff < total))
   `BPRE_ASSERT_IMP(a_pad_is_zero, clock, reset, out_valid_ff && out_pad_ff, out_byte_ff == 8'd0)
endmodule

// ===== rtl/bmp_pixel_row_encoder.sv =====
// Pixel row encoder top level: registers, front end, job queue, back end.
//
// Turns RGB pixel items into the bytes of a BMP pixel array, one output
// item per byte, and pads each row with zero bytes to a four-byte boundary
// (is_padding marks those; last_of_item marks the final byte a pixel
// causes). Palette-load items (kind 0) write one palette entry and produce
// no output. In 24-bit and 16-bit mode a pixel's bytes leave at one per
// cycle through the single-byte output port while the output is ready. In
// 8-bit mode the palette lives in a single-port memory that is searched one
// entry per cycle; a pixel holds the front end through its search, and the
// first match ends the search early; no match yields 255. Unwritten palette
// entries are not cleared after reset and must not fall inside the searched
// range. A two-entry job queue lets input and output stall independently.
// Configuration is written through csr_we/csr_index/csr_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
`include "bmp_pixel_row_encoder_defines.svh"
module bmp_pixel_row_encoder #(
   parameter int PALETTE_DEPTH = bpre_pkg::PALETTE_DEPTH_DEF,
   parameter int MAX_WIDTH     = bpre_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bpre_req_if.sink                          req_ch,
   bpre_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [bpre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpre_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   // configuration registers
   bpre_pkg::cfg_type cfg_ff, cfg_in;

   // front to queue, queue to back
   logic              push, full, pop, empty;
   bpre_pkg::job_type push_job, head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpre_pkg::CSR_PIXEL_MODE:
               cfg_in.mode = csr_wdata[bpre_pkg::MODE_W-1:0];
            bpre_pkg::CSR_ROW_WIDTH:
               cfg_in.row_width = csr_wdata[bpre_pkg::ROW_W-1:0];
            bpre_pkg::CSR_PALETTE_COUNT:
               cfg_in.palette_count = csr_wdata[bpre_pkg::PCOUNT_W-1:0];
            default: begin
               // unmapped index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= bpre_pkg::MODE_BGR24;
         cfg_ff.row_width     <= bpre_pkg::ROW_W'(1);
         cfg_ff.palette_count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpre_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .MAX_WIDTH     (MAX_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg_i  (cfg_ff),
      .push_o (push),
      .job_o  (push_job),
      .full_i (full)
   );

   bpre_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .job_i   (push_job),
      .full_o  (full),
      .pop_i   (pop),
      .empty_o (empty),
      .head_o  (head_job)
   );

   bpre_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_i  (head_job),
      .empty_i (empty),
      .pop_o   (pop),
      .rsp_ch  (rsp_ch)
   );

   // a queued job always carries at least one data byte
   `BPRE_ASSERT_IMP(a_job_nonempty, clock, reset, push, push_job.nbytes != 2'd0)
endmodule

// ===== tb/sv/bpre_byte_checker.sv =====
// Byte checker for the pixel row encoder: watches the channels, predicts each byte, compares.
module bpre_byte_checker (
   input  logic                              clock,
   input  logic                              reset,
   bpre_req_if                               req_ch,
   bpre_rsp_if                               rsp_ch,
   input  logic                              csr_we,
   input  logic [bpre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpre_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                bytes_pending
);
   typedef struct packed {
      logic [bpre_pkg::BYTE_W-1:0] data;
      logic                        pad;
      logic                        last;
   } array_byte_type;

   array_byte_type                expected_bytes[$];
   logic [bpre_pkg::MODE_W-1:0]   mode_reg;
   logic [bpre_pkg::ROW_W-1:0]    width_reg;
   logic [bpre_pkg::PCOUNT_W-1:0] count_reg;
   int                            column;
   int                            byte_no;
   logic [23:0]                   palette_copy [bpre_pkg::PALETTE_DEPTH_DEF];

   // first slot below the (saturated) count holding this color
   function automatic logic [bpre_pkg::BYTE_W-1:0] palette_index(input logic [23:0] rgb);
      int limit;
      int j;
      limit = (count_reg > bpre_pkg::PALETTE_DEPTH_DEF) ? bpre_pkg::PALETTE_DEPTH_DEF :
              int'(count_reg);
      for (j = 0; j < limit; j++)
         if (palette_copy[j] === rgb)
            return 8'(j);
      return bpre_pkg::NO_MATCH;
   endfunction

   task automatic predict_pixel_bytes(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
      logic [bpre_pkg::BYTE_W-1:0] data [3];
      array_byte_type              entry;
      int                          nbytes;
      int                          npad;
      int                          eff_width;
      int                          i;
      case (mode_reg)
         bpre_pkg::MODE_PAL8: begin
            nbytes  = 1;
            data[0] = palette_index({r, g, b});
         end
         bpre_pkg::MODE_RGB555: begin
            nbytes  = 2;
            data[0] = {g[2:0], b[4:0]};
            data[1] = {1'b0, r[4:0], g[4:3]};
         end
         default: begin
            // 24-bit, and the spare mode code behaves the same
            nbytes  = 3;
            data[0] = b;
            data[1] = g;
            data[2] = r;
         end
      endcase
      eff_width = (width_reg == 0) ? 1 :
                  (width_reg > bpre_pkg::MAX_WIDTH_DEF) ? bpre_pkg::MAX_WIDTH_DEF :
                  int'(width_reg);
      if (column + 1 >= eff_width) begin
         column = 0;
         npad   = (4 - ((nbytes * (eff_width % 4)) % 4)) % 4;
      end else begin
         column = column + 1;
         npad   = 0;
      end
      for (i = 0; i < nbytes + npad; i++) begin
         entry.data = (i < nbytes) ? data[i] : 8'h00;
         entry.pad  = (i >= nbytes);
         entry.last = (i == nbytes + npad - 1);
         expected_bytes.push_back(entry);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("byte %0d: %s expected 0x%0h got 0x%0h", byte_no, what, want, got);
      fail_count++;
   endtask

   task automatic check_byte();
      array_byte_type want;
      byte_no++;
      if (expected_bytes.size() == 0) begin
         report_mismatch("unexpected byte", 8'h00, rsp_ch.out_byte);
         return;
      end
      want = expected_bytes.pop_front();
      if (rsp_ch.out_byte !== want.data)
         report_mismatch("out_byte", want.data, rsp_ch.out_byte);
      if (rsp_ch.is_padding !== want.pad)
         report_mismatch("is_padding", 8'(want.pad), 8'(rsp_ch.is_padding));
      if (rsp_ch.last_of_item !== want.last)
         report_mismatch("last_of_item", 8'(want.last), 8'(rsp_ch.last_of_item));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_reg   = bpre_pkg::MODE_BGR24;
         width_reg  = 13'd1;
         count_reg  = 9'd0;
         column     = 0;
         byte_no    = 0;
         fail_count = 0;
         expected_bytes.delete();
      end else begin
         if (csr_we)
            case (csr_index)
               bpre_pkg::CSR_PIXEL_MODE:
                  mode_reg  = csr_wdata[bpre_pkg::MODE_W-1:0];
               bpre_pkg::CSR_ROW_WIDTH:
                  width_reg = csr_wdata[bpre_pkg::ROW_W-1:0];
               bpre_pkg::CSR_PALETTE_COUNT:
                  count_reg = csr_wdata[bpre_pkg::PCOUNT_W-1:0];
               default: ;
            endcase
         // item order matters: a load lands before any later pixel searches
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.kind == bpre_pkg::KIND_LOAD)
               palette_copy[req_ch.entry_index] = {req_ch.red, req_ch.green, req_ch.blue};
            else
               predict_pixel_bytes(req_ch.red, req_ch.green, req_ch.blue);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            check_byte();
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

// ===== tb/sv/bmp_pixel_row_encoder_test.sv =====
// Top of the pixel row encoder test: clock, reset, stimulus, output stalls and verdict.
module bmp_pixel_row_encoder_test;

   localparam int TOTAL_ITEMS   = 470;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;      // covers a trailing load still in flight

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [bpre_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bpre_pkg::CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int bytes_pending;
   int cycle_count = 0;
   int items_sent;
   int req_idle_pct;
   int rsp_idle_pct;

   // colors written to each palette slot, used to aim pixels at real entries
   logic [23:0] palette_colors [bpre_pkg::PALETTE_DEPTH_DEF];

   bpre_req_if req_ch ();
   bpre_rsp_if rsp_ch ();

   bmp_pixel_row_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bpre_byte_checker byte_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // idle cycles before the next item; pct = chance that this item waits at all
   function automatic int draw_gap(input int pct);
      return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 19) : 0;
   endfunction

   // per-phase idling level: none, light, heavy, always
   function automatic int idle_level();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 20;
         2:       return 60;
         default: return 100;
      endcase
   endfunction

   // pixel color; in 8-bit mode mostly a palette color so matches happen
   function automatic logic [23:0] pick_pixel(input logic [bpre_pkg::MODE_W-1:0] mode);
      int sel;
      sel = $urandom_range(0, 9);
      if (mode == bpre_pkg::MODE_PAL8 && sel < 6)
         return palette_colors[$urandom_range(0, bpre_pkg::PALETTE_DEPTH_DEF - 1)];
      if (sel == 9)
         return {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                 $urandom_range(0, 1) ? 8'hFF : 8'h00,
                 $urandom_range(0, 1) ? 8'hFF : 8'h00};
      return 24'($urandom);
   endfunction

   // Offer one item after a random gap and hold it until the block takes it.
   // Called and returns at a falling edge; valid stays high for back-to-back items.
   task automatic send_item(input logic kind, input logic [7:0] idx, input logic [23:0] rgb);
      int gap;
      gap = draw_gap(req_idle_pct);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.entry_index <= idx;
      req_ch.red         <= rgb[23:16];
      req_ch.green       <= rgb[15:8];
      req_ch.blue        <= rgb[7:0];
      if (kind == bpre_pkg::KIND_LOAD)
         palette_colors[idx] = rgb;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Stop offering items, wait for every predicted byte, then let a load finish.
   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all three registers, one per cycle; only called while idle.
   task automatic set_config(input logic [bpre_pkg::MODE_W-1:0] mode,
                             input logic [bpre_pkg::ROW_W-1:0] width,
                             input logic [bpre_pkg::PCOUNT_W-1:0] count);
      csr_we    <= 1'b1;
      csr_index <= bpre_pkg::CSR_PIXEL_MODE;
      csr_wdata <= bpre_pkg::CSR_DATA_W'(mode);
      @(negedge clock);
      csr_index <= bpre_pkg::CSR_ROW_WIDTH;
      csr_wdata <= bpre_pkg::CSR_DATA_W'(width);
      @(negedge clock);
      csr_index <= bpre_pkg::CSR_PALETTE_COUNT;
      csr_wdata <= bpre_pkg::CSR_DATA_W'(count);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Output side: random back-pressure, one draw per byte taken.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(rsp_idle_pct);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      logic [bpre_pkg::MODE_W-1:0]   mode;
      logic [bpre_pkg::ROW_W-1:0]    width;
      logic [bpre_pkg::PCOUNT_W-1:0] count;
      int                            phase_len;
      int                            k;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = bpre_pkg::CSR_PIXEL_MODE;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = bpre_pkg::KIND_LOAD;
      req_ch.entry_index = 8'h00;
      req_ch.red         = 8'h00;
      req_ch.green       = 8'h00;
      req_ch.blue        = 8'h00;
      req_idle_pct       = 50;
      rsp_idle_pct       = 50;
      items_sent         = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // power-on settings: 24-bit, one pixel per row -> B,G,R plus one pad zero
      send_item(bpre_pkg::KIND_PIXEL, 8'h00, 24'h000000);
      send_item(bpre_pkg::KIND_PIXEL, 8'hFF, 24'hFFFFFF);
      send_item(bpre_pkg::KIND_PIXEL, 8'h5A, 24'hA55A3C);

      // tiny palette; white sits in two slots so the lower one must win
      send_item(bpre_pkg::KIND_LOAD, 8'd0, 24'h000000);
      send_item(bpre_pkg::KIND_LOAD, 8'd1, 24'hFFFFFF);
      send_item(bpre_pkg::KIND_LOAD, 8'd2, 24'h123456);
      send_item(bpre_pkg::KIND_LOAD, 8'd3, 24'hFFFFFF);

      // 8-bit, three pixels per row: first match, exact match, no match
      drain_and_settle();
      set_config(bpre_pkg::MODE_PAL8, 13'd3, 9'd4);
      send_item(bpre_pkg::KIND_PIXEL, 8'hA5, 24'hFFFFFF);
      send_item(bpre_pkg::KIND_PIXEL, 8'h00, 24'h123456);
      send_item(bpre_pkg::KIND_PIXEL, 8'hFF, 24'h000000);
      send_item(bpre_pkg::KIND_PIXEL, 8'h3C, 24'h654321);

      // 16-bit with a zero row width (one pixel per row): upper component bits
      // dropped, green split across both bytes
      drain_and_settle();
      set_config(bpre_pkg::MODE_RGB555, 13'd0, 9'd0);
      send_item(bpre_pkg::KIND_PIXEL, 8'h00, 24'hFFFFFF);
      send_item(bpre_pkg::KIND_PIXEL, 8'h00, 24'hE0E0E0);
      send_item(bpre_pkg::KIND_PIXEL, 8'h00, 24'h001800);

      // spare mode code, widest row and top count: no row end here
      drain_and_settle();
      set_config(2'd3, 13'h1FFF, 9'h1FF);
      send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), 24'($urandom));
      send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), 24'($urandom));
      send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), 24'($urandom));

      // width lowered below the current column: the next pixel closes the row
      drain_and_settle();
      set_config(bpre_pkg::MODE_BGR24, 13'd2, 9'd0);
      send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), 24'($urandom));
      send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), 24'($urandom));
      send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), 24'($urandom));

      // --- fill every palette slot so any count is legal from here on ---
      // half the colors come from a small set, which gives repeated entries
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      for (k = 0; k < bpre_pkg::PALETTE_DEPTH_DEF; k++)
         send_item(bpre_pkg::KIND_LOAD, 8'(k), $urandom_range(0, 1) ?
                   24'($urandom_range(0, 7)) * 24'h242424 : 24'($urandom));

      // --- random phases: new settings, new idling, a run of items ---
      while (items_sent < TOTAL_ITEMS) begin
         drain_and_settle();
         mode = bpre_pkg::MODE_W'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:             width = 13'd0;
            1:             width = 13'd1;
            2, 3, 4, 5, 6: width = bpre_pkg::ROW_W'($urandom_range(2, 8));
            7, 8:          width = bpre_pkg::ROW_W'($urandom_range(9, 40));
            default:       width = bpre_pkg::ROW_W'($urandom_range(0, 8191));
         endcase
         case ($urandom_range(0, 7))
            0:       count = 9'd0;
            1:       count = 9'd1;
            2:       count = 9'd256;
            3:       count = bpre_pkg::PCOUNT_W'($urandom_range(257, 511));
            default: count = bpre_pkg::PCOUNT_W'($urandom_range(2, 255));
         endcase
         set_config(mode, width, count);
         req_idle_pct = idle_level();
         rsp_idle_pct = idle_level();
         phase_len    = $urandom_range(8, 40);
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < 12)
               send_item(bpre_pkg::KIND_LOAD, 8'($urandom), 24'($urandom));
            else
               send_item(bpre_pkg::KIND_PIXEL, 8'($urandom), pick_pixel(mode));
         end
      end

      // all items taken: wait out the last bytes and any stray output
      drain_and_settle();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== bmp_pixel_row_encoder.f =====
+incdir+rtl
rtl/bpre_pkg.sv
rtl/bpre_req_if.sv
rtl/bpre_rsp_if.sv
rtl/bpre_queue.sv
rtl/bpre_front.sv
rtl/bpre_back.sv
rtl/bmp_pixel_row_encoder.sv
tb/sv/bpre_byte_checker.sv
tb/sv/bmp_pixel_row_encoder_test.sv
